// File: sv/qnl_pkg.sv
// Shared constants for the quaternion shortest-arc nlerp pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none
package qnl_pkg;
    localparam int COMPONENT_WIDTH_DEF = 16;
    localparam int WEIGHT_W            = 17;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
    localparam int NORM_BITS           = 30;
    localparam int SQ_SUM_W            = 2 * NORM_BITS + 2;
    localparam int ROOT_W              = SQ_SUM_W / 2;
endpackage
`default_nettype wire

// File: sv/qnl_sqrt.sv
// Pipelined integer square root, one result bit per stage, sideband carried along.
// Depends on qnl_pkg.
`default_nettype none
module qnl_sqrt #(
    parameter int IN_W = qnl_pkg::SQ_SUM_W,
    parameter int SB_W = 1
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_valid,
    input  wire logic [IN_W-1:0]      i_n,
    input  wire logic [SB_W-1:0]      i_sb,
    output logic                      o_valid,
    output logic [IN_W/2-1:0]         o_root,
    output logic [SB_W-1:0]           o_sb
);
    import qnl_pkg::*;

    localparam int STEPS = IN_W / 2;

    logic [IN_W-1:0] r_n   [STEPS];
    logic [IN_W-1:0] r_res [STEPS];
    logic [SB_W-1:0] r_sb  [STEPS];
    logic            r_vld [STEPS];

    for (genvar s = 0; s < STEPS; s++) begin : g_step
        localparam logic [IN_W-1:0] STEP_BIT =
            {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * s);
        logic [IN_W-1:0] w_n, w_res, w_try, n_n, n_res;
        logic [SB_W-1:0] w_sb;
        logic            w_vld;

        if (s == 0) begin : g_first
            assign w_n   = i_n;
            assign w_res = '0;
            assign w_sb  = i_sb;
            assign w_vld = i_valid;
        end else begin : g_next
            assign w_n   = r_n[s-1];
            assign w_res = r_res[s-1];
            assign w_sb  = r_sb[s-1];
            assign w_vld = r_vld[s-1];
        end

        always_comb begin
            w_try = w_res + STEP_BIT;
            if (w_n >= w_try) begin
                n_n   = w_n - w_try;
                n_res = (w_res >> 1) + STEP_BIT;
            end else begin
                n_n   = w_n;
                n_res = w_res >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            r_n[s]   <= n_n;
            r_res[s] <= n_res;
            r_sb[s]  <= w_sb;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end
    end

    assign o_valid = r_vld[STEPS-1];
    assign o_root  = r_res[STEPS-1][IN_W/2-1:0];
    assign o_sb    = r_sb[STEPS-1];
endmodule
`default_nettype wire

// File: sv/qnl_div.sv
// Pipelined restoring divider for one lane: q = floor((2*v*2^F + len) / (2*len)).
// Depends on qnl_pkg.
`default_nettype none
module qnl_div #(
    parameter int FRAC = qnl_pkg::COMPONENT_WIDTH_DEF - 2,
    parameter int SB_W = 1
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    input  wire logic [qnl_pkg::NORM_BITS-1:0] i_v,
    input  wire logic [qnl_pkg::ROOT_W-1:0]   i_len,
    input  wire logic [SB_W-1:0]              i_sb,
    output logic                              o_valid,
    output logic [FRAC:0]                     o_q,
    output logic [SB_W-1:0]                   o_sb
);
    import qnl_pkg::*;

    localparam int QW    = FRAC + 1;
    localparam int DW    = ROOT_W + 1;
    localparam int NUM_W = NORM_BITS + QW + 2;

    logic [NUM_W-1:0] w_num;
    logic [DW-1:0]    w_den;

    assign w_num = (NUM_W'(i_v) << QW) + NUM_W'(i_len);
    assign w_den = {i_len, 1'b0};

    logic [DW-1:0]   r_rem [QW];
    logic [QW-1:0]   r_low [QW];
    logic [QW-1:0]   r_q   [QW];
    logic [DW-1:0]   r_den [QW];
    logic [SB_W-1:0] r_sb  [QW];
    logic            r_vld [QW];

    for (genvar s = 0; s < QW; s++) begin : g_step
        logic [DW-1:0]   w_rem, w_d, n_rem;
        logic [QW-1:0]   w_low, w_q, n_q;
        logic [DW:0]     w_try;
        logic [SB_W-1:0] w_sb;
        logic            w_vld;

        if (s == 0) begin : g_first
            assign w_rem = DW'(w_num >> QW);
            assign w_low = w_num[QW-1:0];
            assign w_q   = '0;
            assign w_d   = w_den;
            assign w_sb  = i_sb;
            assign w_vld = i_valid;
        end else begin : g_next
            assign w_rem = r_rem[s-1];
            assign w_low = r_low[s-1];
            assign w_q   = r_q[s-1];
            assign w_d   = r_den[s-1];
            assign w_sb  = r_sb[s-1];
            assign w_vld = r_vld[s-1];
        end

        always_comb begin
            w_try = {w_rem, w_low[QW-1]};
            if (w_try >= {1'b0, w_d}) begin
                n_rem = DW'(w_try - {1'b0, w_d});
                n_q   = {w_q[QW-2:0], 1'b1};
            end else begin
                n_rem = w_try[DW-1:0];
                n_q   = {w_q[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[s] <= n_rem;
            r_low[s] <= w_low << 1;
            r_q[s]   <= n_q;
            r_den[s] <= w_d;
            r_sb[s]  <= w_sb;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else begin
                r_vld[s] <= w_vld;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_q     = r_q[QW-1];
    assign o_sb    = r_sb[QW-1];
endmodule
`default_nettype wire

// File: sv/quaternion_nlerp_shortest_arc.sv
// Top level: shortest-arc quaternion blend with normalization, fully pipelined.
// Depends on qnl_pkg, qnl_sqrt and qnl_div.
//
//  channel  | ports                                  | dir | beat
//  ---------+----------------------------------------+-----+---------------------------
//  command  | i_start, o_busy, i_a_*, i_b_*,         | in  | i_start & !o_busy
//           | i_blend_weight                         |     |
//  result   | o_valid, o_r_*, o_degenerate           | out | o_valid, one cycle
//
// One beat enters every cycle; o_busy stays low. The pipeline is 11 front stages
// (saturate, dot, blend, normalize, squares), 31 square-root stages,
// COMPONENT_WIDTH-1 divider stages and one output register.
// Reset clears only the valid bits. Results cannot be held off by the receiver.
`default_nettype none
module quaternion_nlerp_shortest_arc #(
    parameter int COMPONENT_WIDTH = qnl_pkg::COMPONENT_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_a_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_a_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_a_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_a_z,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_b_w,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_b_x,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_b_y,
    input  wire logic signed [COMPONENT_WIDTH-1:0] i_b_z,
    input  wire logic [qnl_pkg::WEIGHT_W-1:0]      i_blend_weight,
    output logic                                   o_valid,
    output logic signed [COMPONENT_WIDTH-1:0]      o_r_w,
    output logic signed [COMPONENT_WIDTH-1:0]      o_r_x,
    output logic signed [COMPONENT_WIDTH-1:0]      o_r_y,
    output logic signed [COMPONENT_WIDTH-1:0]      o_r_z,
    output logic                                   o_degenerate
);
    import qnl_pkg::*;

    localparam int CW   = COMPONENT_WIDTH;
    localparam int FRAC = CW - 2;
    localparam int QW   = FRAC + 1;
    localparam int PW   = CW + 18;
    localparam int MW   = CW + 15;
    localparam int BLW  = $clog2(MW + 1);
    localparam int VW   = NORM_BITS;
    localparam int SQW  = 2 * VW;
    localparam int SBW  = 4 * VW + 5;
    localparam logic signed [CW-1:0] ONE_S = {2'b01, {FRAC{1'b0}}};
    localparam logic signed [CW-1:0] NEG_ONE_S = {2'b11, {FRAC{1'b0}}};
    localparam logic [QW-1:0] ONE_Q = {1'b1, {FRAC{1'b0}}};

    function automatic logic [BLW-1:0] bit_len(input logic [MW-1:0] m);
        logic [BLW-1:0] n;
        n = '0;
        for (int i = 0; i < MW; i++) begin
            if (m[i]) begin
                n = BLW'(i + 1);
            end
        end
        return n;
    endfunction

    assign o_busy = 1'b0;

    logic signed [CW-1:0] w_a [4];
    logic signed [CW-1:0] w_b [4];
    assign w_a = '{i_a_w, i_a_x, i_a_y, i_a_z};
    assign w_b = '{i_b_w, i_b_x, i_b_y, i_b_z};

    // stage 1: saturate
    logic signed [CW-1:0]  r1_a [4], r1_b [4];
    logic [WEIGHT_W-1:0]   r1_t;
    // stage 2: dot products
    logic signed [CW-1:0]  r2_a [4], r2_b [4];
    logic signed [2*CW-1:0] r2_p [4];
    logic [WEIGHT_W-1:0]   r2_t;
    // stage 3: pick arc
    logic signed [CW-1:0]  r3_a [4], r3_b [4];
    logic [WEIGHT_W-1:0]   r3_t;
    // stage 4: weighted terms
    logic signed [PW-1:0]  r4_pa [4], r4_pb [4];
    // stage 5..8: magnitude, max, bit length, normalize
    logic [MW-1:0]         r5_mag [4], r6_mag [4], r7_mag [4];
    logic [3:0]            r5_neg, r6_neg, r7_neg, r8_neg, r9_neg, r10_neg, r11_neg;
    logic [MW-1:0]         r6_m;
    logic [BLW-1:0]        r7_bl;
    logic                  r7_deg, r8_deg, r9_deg, r10_deg, r11_deg;
    logic [VW-1:0]         r8_v [4], r9_v [4], r10_v [4], r11_v [4];
    logic [SQW-1:0]        r9_sq [4];
    logic [SQW:0]          r10_s01, r10_s23;
    logic [SQ_SUM_W-1:0]   r11_n2;
    logic [10:0]           r_vld;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r1_a[i] <= (w_a[i] > ONE_S) ? ONE_S : ((w_a[i] < NEG_ONE_S) ? NEG_ONE_S : w_a[i]);
            r1_b[i] <= (w_b[i] > ONE_S) ? ONE_S : ((w_b[i] < NEG_ONE_S) ? NEG_ONE_S : w_b[i]);
        end
        r1_t <= (i_blend_weight > WEIGHT_ONE) ? WEIGHT_ONE : i_blend_weight;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r2_a[i] <= r1_a[i];
            r2_b[i] <= r1_b[i];
            r2_p[i] <= r1_a[i] * r1_b[i];
        end
        r2_t <= r1_t;
    end

    logic signed [2*CW+1:0] w_dot;
    assign w_dot = (2*CW+2)'(r2_p[0]) + (2*CW+2)'(r2_p[1])
                 + (2*CW+2)'(r2_p[2]) + (2*CW+2)'(r2_p[3]);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r3_a[i] <= r2_a[i];
            r3_b[i] <= w_dot[2*CW+1] ? -r2_b[i] : r2_b[i];
        end
        r3_t <= r2_t;
    end

    logic signed [WEIGHT_W:0] w_wa, w_wb;
    assign w_wa = $signed({1'b0, WEIGHT_ONE - r3_t});
    assign w_wb = $signed({1'b0, r3_t});

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r4_pa[i] <= w_wa * r3_a[i];
            r4_pb[i] <= w_wb * r3_b[i];
        end
    end

    logic signed [PW:0] w_c [4], w_abs [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_c[i]   = (PW+1)'(r4_pa[i]) + (PW+1)'(r4_pb[i]);
            w_abs[i] = w_c[i][PW] ? -w_c[i] : w_c[i];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r5_mag[i] <= w_abs[i][MW-1:0];
            r5_neg[i] <= w_c[i][PW];
        end
    end

    logic [MW-1:0] w_m01, w_m23;
    assign w_m01 = (r5_mag[0] > r5_mag[1]) ? r5_mag[0] : r5_mag[1];
    assign w_m23 = (r5_mag[2] > r5_mag[3]) ? r5_mag[2] : r5_mag[3];

    always_ff @(posedge i_clk) begin
        r6_mag <= r5_mag;
        r6_neg <= r5_neg;
        r6_m   <= (w_m01 > w_m23) ? w_m01 : w_m23;
    end

    always_ff @(posedge i_clk) begin
        r7_mag <= r6_mag;
        r7_neg <= r6_neg;
        r7_bl  <= bit_len(r6_m);
        r7_deg <= (r6_m == '0);
    end

    logic [MW+VW-1:0] w_sh [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_sh[i] = {r7_mag[i], {VW{1'b0}}} >> r7_bl;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r8_v[i] <= w_sh[i][VW-1:0];
        end
        r8_neg <= r7_neg;
        r8_deg <= r7_deg;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 4; i++) begin
            r9_sq[i] <= r8_v[i] * r8_v[i];
        end
        r9_v   <= r8_v;
        r9_neg <= r8_neg;
        r9_deg <= r8_deg;
    end

    always_ff @(posedge i_clk) begin
        r10_s01 <= (SQW+1)'(r9_sq[0]) + (SQW+1)'(r9_sq[1]);
        r10_s23 <= (SQW+1)'(r9_sq[2]) + (SQW+1)'(r9_sq[3]);
        r10_v   <= r9_v;
        r10_neg <= r9_neg;
        r10_deg <= r9_deg;
    end

    always_ff @(posedge i_clk) begin
        r11_n2  <= SQ_SUM_W'(r10_s01) + SQ_SUM_W'(r10_s23);
        r11_v   <= r10_v;
        r11_neg <= r10_neg;
        r11_deg <= r10_deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[9:0], i_start};
        end
    end

    logic              w_sq_vld;
    logic [ROOT_W-1:0] w_len;
    logic [SBW-1:0]    w_sq_sb;

    qnl_sqrt #(
        .IN_W (SQ_SUM_W),
        .SB_W (SBW)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld[10]),
        .i_n     (r11_n2),
        .i_sb    ({r11_v[3], r11_v[2], r11_v[1], r11_v[0], r11_neg, r11_deg}),
        .o_valid (w_sq_vld),
        .o_root  (w_len),
        .o_sb    (w_sq_sb)
    );

    logic          w_dv_vld [4];
    logic [QW-1:0] w_q [4];
    logic [1:0]    w_dv_sb [4];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        qnl_div #(
            .FRAC (FRAC),
            .SB_W (2)
        ) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_sq_vld),
            .i_v     (w_sq_sb[5 + l*VW +: VW]),
            .i_len   (w_len),
            .i_sb    ({w_sq_sb[0], w_sq_sb[1 + l]}),
            .o_valid (w_dv_vld[l]),
            .o_q     (w_q[l]),
            .o_sb    (w_dv_sb[l])
        );
    end

    logic signed [CW-1:0] w_r [4];
    logic [QW-1:0]        w_qs [4];
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_qs[i] = (w_q[i] > ONE_Q) ? ONE_Q : w_q[i];
            w_r[i]  = w_dv_sb[i][0] ? -$signed(CW'(w_qs[i])) : $signed(CW'(w_qs[i]));
        end
    end

    logic w_deg;
    assign w_deg = w_dv_sb[0][1];

    always_ff @(posedge i_clk) begin
        o_r_w        <= w_deg ? ONE_S : w_r[0];
        o_r_x        <= w_deg ? '0 : w_r[1];
        o_r_y        <= w_deg ? '0 : w_r[2];
        o_r_z        <= w_deg ? '0 : w_r[3];
        o_degenerate <= w_deg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= w_dv_vld[0] & w_dv_vld[1] & w_dv_vld[2] & w_dv_vld[3];
        end
    end
endmodule
`default_nettype wire

// File: verif/tb_quaternion_nlerp_shortest_arc.sv
// Testbench for quaternion_nlerp_shortest_arc: drives quaternion pairs and weights,
// predicts each normalized shortest-arc blend and checks every result beat.
// Depends on qnl_pkg and the quaternion_nlerp_shortest_arc RTL.
`timescale 1ns / 100ps
module tb_quaternion_nlerp_shortest_arc;
    import qnl_pkg::*;

    localparam int CW = COMPONENT_WIDTH_DEF;
    localparam int FB = CW - 2;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES = CW + 60;

    typedef struct packed {
        logic signed [CW-1:0] a_w, a_x, a_y, a_z;
        logic signed [CW-1:0] b_w, b_x, b_y, b_z;
        logic [WEIGHT_W-1:0]  blend_weight;
    } blend_req_t;

    typedef struct packed {
        logic signed [CW-1:0] r_w, r_x, r_y, r_z;
        logic                 degenerate;
    } blend_res_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_start;
    logic                 o_busy;
    logic signed [CW-1:0] i_a_w, i_a_x, i_a_y, i_a_z;
    logic signed [CW-1:0] i_b_w, i_b_x, i_b_y, i_b_z;
    logic [WEIGHT_W-1:0]  i_blend_weight;
    logic                 o_valid;
    logic signed [CW-1:0] o_r_w, o_r_x, o_r_y, o_r_z;
    logic                 o_degenerate;

    blend_req_t pending_reqs[$];
    blend_res_t expected_blends[$];
    int         gap_pct;
    bit         hold_send;
    int         error_count;
    int         idle_cycles;

    quaternion_nlerp_shortest_arc DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_a_w(i_a_w), .i_a_x(i_a_x), .i_a_y(i_a_y), .i_a_z(i_a_z),
        .i_b_w(i_b_w), .i_b_x(i_b_x), .i_b_y(i_b_y), .i_b_z(i_b_z),
        .i_blend_weight(i_blend_weight), .o_valid(o_valid),
        .o_r_w(o_r_w), .o_r_x(o_r_x), .o_r_y(o_r_y), .o_r_z(o_r_z),
        .o_degenerate(o_degenerate)
    );

    function automatic longint clamp_unit(logic signed [CW-1:0] raw);
        longint s;
        s = raw;
        if (s > (64'sd1 <<< FB)) s = 64'sd1 <<< FB;
        if (s < -(64'sd1 <<< FB)) s = -(64'sd1 <<< FB);
        return s;
    endfunction

    function automatic longint unsigned isqrt(longint unsigned n);
        longint unsigned root, bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic blend_res_t nlerp_shortest(blend_req_t q);
        longint          qa[4], qb[4], c;
        longint          dot, wt;
        longint unsigned mag[4], peak, sq_sum, len, unit, r;
        bit              neg[4];
        int              msb;
        blend_res_t      res;
        logic signed [CW-1:0] comp[4];
        qa[0] = clamp_unit(q.a_w); qa[1] = clamp_unit(q.a_x);
        qa[2] = clamp_unit(q.a_y); qa[3] = clamp_unit(q.a_z);
        qb[0] = clamp_unit(q.b_w); qb[1] = clamp_unit(q.b_x);
        qb[2] = clamp_unit(q.b_y); qb[3] = clamp_unit(q.b_z);
        dot = 0;
        for (int i = 0; i < 4; i++) dot += qa[i] * qb[i];
        wt = (q.blend_weight > WEIGHT_ONE) ? 65536 : q.blend_weight;
        peak = 0;
        for (int i = 0; i < 4; i++) begin
            if (dot < 0) qb[i] = -qb[i];
            c = (65536 - wt) * qa[i] + wt * qb[i];
            neg[i] = c < 0;
            mag[i] = neg[i] ? -c : c;
            if (mag[i] > peak) peak = mag[i];
        end
        unit = 64'd1 << FB;
        if (peak == 0) begin
            res.r_w = CW'(unit);
            res.r_x = '0;
            res.r_y = '0;
            res.r_z = '0;
            res.degenerate = 1'b1;
            return res;
        end
        msb = 0;
        while (peak != 0) begin
            msb++;
            peak >>= 1;
        end
        sq_sum = 0;
        for (int i = 0; i < 4; i++) begin
            if (msb > NORM_BITS) mag[i] >>= (msb - NORM_BITS);
            else mag[i] <<= (NORM_BITS - msb);
            sq_sum += mag[i] * mag[i];
        end
        len = isqrt(sq_sum);
        for (int i = 0; i < 4; i++) begin
            r = (2 * mag[i] * unit + len) / (2 * len);
            if (r > unit) r = unit;
            comp[i] = CW'(neg[i] ? -r : r);
        end
        res.r_w = comp[0];
        res.r_x = comp[1];
        res.r_y = comp[2];
        res.r_z = comp[3];
        res.degenerate = 1'b0;
        return res;
    endfunction

    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return CW'($urandom);
            1: return 16'sd16384;
            2: return -16'sd16384;
            3: return CW'($urandom_range(0, 64) - 32);
            default: return CW'($urandom_range(0, 32768) - 16384);
        endcase
    endfunction

    function automatic blend_req_t rand_req();
        blend_req_t q;
        q.a_w = rand_comp(); q.a_x = rand_comp(); q.a_y = rand_comp(); q.a_z = rand_comp();
        if ($urandom_range(0, 5) == 0) begin
            q.b_w = -q.a_w; q.b_x = -q.a_x; q.b_y = -q.a_y; q.b_z = -q.a_z;
        end else begin
            q.b_w = rand_comp(); q.b_x = rand_comp(); q.b_y = rand_comp();
            q.b_z = rand_comp();
        end
        case ($urandom_range(0, 7))
            0: q.blend_weight = '0;
            1: q.blend_weight = WEIGHT_ONE;
            2: q.blend_weight = 17'd32768;
            3: q.blend_weight = WEIGHT_W'($urandom);
            default: q.blend_weight = WEIGHT_W'($urandom_range(0, 65536));
        endcase
        return q;
    endfunction

    function automatic blend_req_t make_req(int aw, int ax, int ay, int az,
                                            int bw, int bx, int by, int bz, int t);
        blend_req_t q;
        q.a_w = CW'(aw); q.a_x = CW'(ax); q.a_y = CW'(ay); q.a_z = CW'(az);
        q.b_w = CW'(bw); q.b_x = CW'(bx); q.b_y = CW'(by); q.b_z = CW'(bz);
        q.blend_weight = WEIGHT_W'(t);
        return q;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !o_busy) begin
            expected_blends.push_back(nlerp_shortest({i_a_w, i_a_x, i_a_y, i_a_z,
                i_b_w, i_b_x, i_b_y, i_b_z, i_blend_weight}));
            if (pending_reqs.size() > 0 && !hold_send && $urandom_range(0, 99) >= gap_pct) begin
                {i_a_w, i_a_x, i_a_y, i_a_z, i_b_w, i_b_x, i_b_y, i_b_z, i_blend_weight}
                    <= pending_reqs.pop_front();
            end else begin
                i_start <= 1'b0;
            end
        end else if (!i_start && pending_reqs.size() > 0 && !hold_send
                     && $urandom_range(0, 99) >= gap_pct) begin
            {i_a_w, i_a_x, i_a_y, i_a_z, i_b_w, i_b_x, i_b_y, i_b_z, i_blend_weight}
                <= pending_reqs.pop_front();
            i_start <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        blend_res_t exp_res;
        if (i_rst_n && o_valid) begin
            if (expected_blends.size() == 0) begin
                $display("%0t: unexpected result w=%0d x=%0d y=%0d z=%0d deg=%0b", $time,
                         o_r_w, o_r_x, o_r_y, o_r_z, o_degenerate);
                error_count++;
            end else begin
                exp_res = expected_blends.pop_front();
                if (exp_res.r_w !== o_r_w) begin
                    $display("%0t: r_w expected %0d actual %0d", $time, exp_res.r_w, o_r_w);
                    error_count++;
                end
                if (exp_res.r_x !== o_r_x) begin
                    $display("%0t: r_x expected %0d actual %0d", $time, exp_res.r_x, o_r_x);
                    error_count++;
                end
                if (exp_res.r_y !== o_r_y) begin
                    $display("%0t: r_y expected %0d actual %0d", $time, exp_res.r_y, o_r_y);
                    error_count++;
                end
                if (exp_res.r_z !== o_r_z) begin
                    $display("%0t: r_z expected %0d actual %0d", $time, exp_res.r_z, o_r_z);
                    error_count++;
                end
                if (exp_res.degenerate !== o_degenerate) begin
                    $display("%0t: degenerate expected %0b actual %0b", $time,
                             exp_res.degenerate, o_degenerate);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_valid) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_start = 1'b0;
        {i_a_w, i_a_x, i_a_y, i_a_z, i_b_w, i_b_x, i_b_y, i_b_z, i_blend_weight} = '0;
        gap_pct = 30;
        hold_send = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 32768));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, -16384, 0, 0, 0, 65536));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 16384, 0, 0, 65536));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, 0, 16384, 0, 131071));
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 0, 0, 12345));
        pending_reqs.push_back(make_req(16384, 16384, 0, 0, -16384, -16384, 0, 0, 32768));
        pending_reqs.push_back(make_req(32767, -32768, 20000, -20000, 0, 0, 0, 16384, 100));
        pending_reqs.push_back(make_req(-16384, -16384, -16384, -16384,
                                        16384, 16384, 16384, 16384, 40000));
        pending_reqs.push_back(make_req(1, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_req(0, 0, 0, -1, 0, 1, 0, 0, 65535));
        pending_reqs.push_back(make_req(16384, 0, 0, 0, 0, -16384, 0, 0, 1));
        pending_reqs.push_back(make_req(0, 1, 0, 0, 0, 1, 0, 0, 70000));
        pending_reqs.push_back(make_req(8192, 8192, 8192, 8192,
                                        -8192, 8192, -8192, 8192, 65536));
        pending_reqs.push_back(make_req(-1, -1, -1, -1, -1, -1, -1, -1, 98304));
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int phase = 0; phase < 3; phase++) begin
            gap_pct = (phase == 0) ? 30 : (phase == 1) ? 46 : 0;
            for (int k = 0; k < 360; k++) pending_reqs.push_back(rand_req());
            wait (pending_reqs.size() == 0 && !i_start);
            if (phase == 0) begin
                hold_send = 1'b1;
                wait (expected_blends.size() == 0);
                hold_send = 1'b0;
            end
        end
        wait (expected_blends.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end
endmodule
